[sv/ppw_pkg.sv]
`timescale 1ns / 1ps
package ppw_pkg;

  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 16;
  localparam int MAG_W      = LEVEL_W + 1;
  localparam int PROD_W     = MAG_W + TIME_W;
  localparam int STEPS      = 4;
  localparam int MOD_STAGES = (TIME_W + STEPS - 1) / STEPS;
  localparam int DIV_STAGES = (MAG_W + STEPS - 1) / STEPS;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    SEG_DELAY = 3'd0,
    SEG_RISE  = 3'd1,
    SEG_TOP   = 3'd2,
    SEG_FALL  = 3'd3,
    SEG_REST  = 3'd4
  } seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 3'd0,
    REG_PULSE  = 3'd1,
    REG_DELAY  = 3'd2,
    REG_RISE   = 3'd3,
    REG_FALL   = 3'd4,
    REG_TOP    = 3'd5,
    REG_PERIOD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    seg_t seg;
    logic neg;
  } tag_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] r,
                                               input logic b,
                                               input logic [TIME_W-1:0] d);
    logic [TIME_W:0] sh;
    logic [TIME_W:0] df;
    begin
      sh = {r, b};
      df = sh - {1'b0, d};
      if (sh >= {1'b0, d}) begin
        div_step = {1'b1, df[TIME_W-1:0]};
      end else begin
        div_step = {1'b0, sh[TIME_W-1:0]};
      end
    end
  endfunction

endpackage

[sv/ppw_mod.sv]
`timescale 1ns / 1ps
module ppw_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [ppw_pkg::TIME_W-1:0] t_in,
  input  logic [ppw_pkg::TIME_W-1:0] period,
  output logic                      out_v,
  output logic [ppw_pkg::TIME_W-1:0] t_out
);

  localparam int N = ppw_pkg::MOD_STAGES;
  localparam int W = ppw_pkg::TIME_W;

  logic [W-1:0] rem [N];
  logic [W-1:0] dvd [N];
  logic [W-1:0] tor [N];
  logic         vld [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [W-1:0] r_src;
    logic [W-1:0] d_src;
    logic [W-1:0] t_src;
    logic         v_src;
    logic [W-1:0] rr;
    logic [W-1:0] dd;
    logic [W:0]   st;

    if (s == 0) begin : g_first
      assign r_src = '0;
      assign d_src = t_in;
      assign t_src = t_in;
      assign v_src = in_v;
    end else begin : g_next
      assign r_src = rem[s-1];
      assign d_src = dvd[s-1];
      assign t_src = tor[s-1];
      assign v_src = vld[s-1];
    end

    always_comb begin
      rr = r_src;
      dd = d_src;
      st = '0;
      for (int k = 0; k < ppw_pkg::STEPS; k++) begin
        if (s * ppw_pkg::STEPS + k < W) begin
          st = ppw_pkg::div_step(rr, dd[W-1], period);
          rr = st[W-1:0];
          dd = {dd[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_src;
      end
      if (en) begin
        rem[s] <= rr;
        dvd[s] <= dd;
        tor[s] <= t_src;
      end
    end
  end

  assign out_v = vld[N-1];
  assign t_out = (period == '0) ? tor[N-1] : rem[N-1];

endmodule

[sv/ppw_rdiv.sv]
`timescale 1ns / 1ps
module ppw_rdiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [ppw_pkg::PROD_W-1:0] prod,
  input  logic [ppw_pkg::TIME_W-1:0] den,
  input  ppw_pkg::tag_t              tag_in,
  output logic                       out_v,
  output logic [ppw_pkg::MAG_W-1:0]  quo,
  output ppw_pkg::tag_t              tag_out
);

  localparam int N = ppw_pkg::DIV_STAGES;
  localparam int W = ppw_pkg::TIME_W;
  localparam int M = ppw_pkg::MAG_W;

  logic [W-1:0]  rem [N];
  logic [M-1:0]  low [N];
  logic [M-1:0]  qq  [N];
  logic [W-1:0]  dn  [N];
  ppw_pkg::tag_t tg  [N];
  logic          vld [N];

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [W-1:0]  r_src;
    logic [M-1:0]  l_src;
    logic [M-1:0]  q_src;
    logic [W-1:0]  d_src;
    ppw_pkg::tag_t t_src;
    logic          v_src;
    logic [W-1:0]  rr;
    logic [M-1:0]  ll;
    logic [M-1:0]  qv;
    logic [W:0]    st;

    if (s == 0) begin : g_first
      assign r_src = prod[ppw_pkg::PROD_W-1:M];
      assign l_src = prod[M-1:0];
      assign q_src = '0;
      assign d_src = den;
      assign t_src = tag_in;
      assign v_src = in_v;
    end else begin : g_next
      assign r_src = rem[s-1];
      assign l_src = low[s-1];
      assign q_src = qq[s-1];
      assign d_src = dn[s-1];
      assign t_src = tg[s-1];
      assign v_src = vld[s-1];
    end

    always_comb begin
      rr = r_src;
      ll = l_src;
      qv = q_src;
      st = '0;
      for (int k = 0; k < ppw_pkg::STEPS; k++) begin
        if (s * ppw_pkg::STEPS + k < M) begin
          st = ppw_pkg::div_step(rr, ll[M-1], d_src);
          rr = st[W-1:0];
          qv = {qv[M-2:0], st[W]};
          ll = {ll[M-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_src;
      end
      if (en) begin
        rem[s] <= rr;
        low[s] <= ll;
        qq[s]  <= qv;
        dn[s]  <= d_src;
        tg[s]  <= t_src;
      end
    end
  end

  assign out_v   = vld[N-1];
  assign quo     = qq[N-1];
  assign tag_out = tg[N-1];

endmodule

[sv/periodic_pulse_waveform_top.sv]
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in      | request   | in_valid / in_ready    | sample_time
// out     | result    | out_valid / out_ready  | level, segment
// cfg     | write     | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle sustained while the output is not stalled. Stages: 8 modulo
// stages (4 quotient bits each), 2 segment compare stages, 1 multiply stage,
// 5 ramp divide stages and the output register.
// rst clears all valid bits and the configuration registers to 0.
// A stalled output holds every stage in place; in_ready drops with it.
module periodic_pulse_waveform_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppw_pkg::TIME_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ppw_pkg::TIME_W-1:0]    sample_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ppw_pkg::LEVEL_W-1:0] level,
  output logic [2:0]                    segment
);

  localparam int TW = ppw_pkg::TIME_W;
  localparam int LW = ppw_pkg::LEVEL_W;
  localparam int MW = ppw_pkg::MAG_W;
  localparam int PW = ppw_pkg::PROD_W;

  logic signed [LW-1:0] base_level;
  logic signed [LW-1:0] pulse_level;
  logic [TW-1:0] start_delay;
  logic [TW-1:0] rise_ticks;
  logic [TW-1:0] fall_ticks;
  logic [TW-1:0] top_ticks;
  logic [TW-1:0] period_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level   <= '0;
      pulse_level  <= '0;
      start_delay  <= '0;
      rise_ticks   <= '0;
      fall_ticks   <= '0;
      top_ticks    <= '0;
      period_ticks <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppw_pkg::REG_BASE:   base_level   <= cfg_data[LW-1:0];
        ppw_pkg::REG_PULSE:  pulse_level  <= cfg_data[LW-1:0];
        ppw_pkg::REG_DELAY:  start_delay  <= cfg_data;
        ppw_pkg::REG_RISE:   rise_ticks   <= cfg_data;
        ppw_pkg::REG_FALL:   fall_ticks   <= cfg_data;
        ppw_pkg::REG_TOP:    top_ticks    <= cfg_data;
        ppw_pkg::REG_PERIOD: period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [MW-1:0] diff;
  logic [MW-1:0] mag;
  logic rise_neg;
  assign diff     = MW'(pulse_level) - MW'(base_level);
  assign mag      = diff[MW-1] ? MW'(-diff) : diff;
  assign rise_neg = diff[MW-1];

  logic          m_v;
  logic [TW-1:0] tm;

  ppw_mod u_mod (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (in_valid),
    .t_in   (sample_time),
    .period (period_ticks),
    .out_v  (m_v),
    .t_out  (tm)
  );

  logic          c1_v;
  logic          c1_le0;
  logic          c1_inr;
  logic [TW-1:0] c1_rel1;
  logic [TW-1:0] c1_rel2;
  logic [TW-1:0] rel1;
  assign rel1 = tm - start_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (en) begin
      c1_v <= m_v;
    end
    if (en) begin
      c1_le0  <= tm <= start_delay;
      c1_inr  <= rel1 <= rise_ticks;
      c1_rel1 <= rel1;
      c1_rel2 <= rel1 - rise_ticks;
    end
  end

  logic          c2_v;
  ppw_pkg::seg_t c2_seg;
  logic          c2_neg;
  logic [TW-1:0] c2_num;
  logic [TW-1:0] c2_den;
  logic [TW-1:0] rel3;
  ppw_pkg::seg_t seg_sel;
  assign rel3 = c1_rel2 - top_ticks;

  always_comb begin
    if (c1_le0) begin
      seg_sel = ppw_pkg::SEG_DELAY;
    end else if (c1_inr) begin
      seg_sel = ppw_pkg::SEG_RISE;
    end else if (c1_rel2 <= top_ticks) begin
      seg_sel = ppw_pkg::SEG_TOP;
    end else if (rel3 <= fall_ticks) begin
      seg_sel = ppw_pkg::SEG_FALL;
    end else begin
      seg_sel = ppw_pkg::SEG_REST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v <= c1_v;
    end
    if (en) begin
      c2_seg <= seg_sel;
      c2_neg <= c1_inr ? rise_neg : !rise_neg;
      c2_num <= c1_inr ? c1_rel1 : rel3;
      c2_den <= c1_inr ? rise_ticks : fall_ticks;
    end
  end

  logic          p_v;
  logic [PW-1:0] p_prod;
  logic [TW-1:0] p_den;
  ppw_pkg::tag_t p_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= c2_v;
    end
    if (en) begin
      p_prod    <= PW'(mag) * PW'(c2_num);
      p_den     <= c2_den;
      p_tag.seg <= c2_seg;
      p_tag.neg <= c2_neg && (diff != '0);
    end
  end

  logic          d_v;
  logic [MW-1:0] d_q;
  ppw_pkg::tag_t d_tag;

  ppw_rdiv u_rdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (p_v),
    .prod    (p_prod),
    .den     (p_den),
    .tag_in  (p_tag),
    .out_v   (d_v),
    .quo     (d_q),
    .tag_out (d_tag)
  );

  logic signed [LW+1:0] from_x;
  logic signed [LW+1:0] q_x;
  logic signed [LW+1:0] ramp_x;
  logic signed [LW-1:0] level_next;

  assign from_x = (d_tag.seg == ppw_pkg::SEG_RISE) ? (LW+2)'(base_level)
                                                   : (LW+2)'(pulse_level);
  assign q_x    = (LW+2)'($signed({1'b0, d_q}));
  assign ramp_x = d_tag.neg ? (from_x - q_x) : (from_x + q_x);

  always_comb begin
    case (d_tag.seg)
      ppw_pkg::SEG_RISE,
      ppw_pkg::SEG_FALL: level_next = ramp_x[LW-1:0];
      ppw_pkg::SEG_TOP:  level_next = pulse_level;
      default:           level_next = base_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v;
    end
    if (en) begin
      level   <= level_next;
      segment <= d_tag.seg;
    end
  end

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (segment <= 3'(ppw_pkg::SEG_REST)))
    else $error("segment code out of range");

  a_top_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && segment == 3'(ppw_pkg::SEG_TOP)) |-> (level == pulse_level))
    else $error("top segment level mismatch");

  a_base_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (segment == 3'(ppw_pkg::SEG_DELAY) ||
                   segment == 3'(ppw_pkg::SEG_REST))) |-> (level == base_level))
    else $error("resting level mismatch");

endmodule
